// File: design/bpd_pkg.sv
package bpd_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_GAIN_P    = 3'd1;
  localparam logic [2:0] REG_GAIN_I    = 3'd2;
  localparam logic [2:0] REG_GAIN_D    = 3'd3;
  localparam logic [2:0] REG_SEP       = 3'd4;
  localparam logic [2:0] REG_RADIUS    = 3'd5;
  localparam logic [2:0] REG_LIMIT     = 3'd6;
  localparam logic [2:0] REG_FALL      = 3'd7;

  // Operating modes
  localparam logic [1:0] MODE_PARK     = 2'd0;
  localparam logic [1:0] MODE_TRACTOR  = 2'd1;
  localparam logic [1:0] MODE_BALANCE  = 2'd2;

  // Reset values
  localparam logic [15:0] RST_GAIN_P   = 16'd512;
  localparam logic [15:0] RST_GAIN_I   = 16'd26;
  localparam logic [15:0] RST_GAIN_D   = 16'd26;
  localparam logic [15:0] RST_SEP      = 16'd4096;
  localparam logic [15:0] RST_RADIUS   = 16'd1024;
  localparam logic [14:0] RST_LIMIT    = 15'd15360;
  localparam logic [14:0] RST_FALL     = 15'd8960;

  // Datapath widths of the shared serial units
  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 32;
  localparam int DIV_N_W = 64;
  localparam int DIV_D_W = 32;

  // Arithmetic constants
  localparam logic [31:0] DEG_PER_RAD_Q16 = 32'd3754936;
  localparam logic [31:0] FALL_DEBOUNCE   = 32'd100000;
  localparam logic [31:0] US_PER_S        = 32'd1000000;
  localparam logic [31:0] I_SCALE         = 32'd256000000;
  localparam logic [31:0] I_SCALE_HALF    = 32'd128000000;
  localparam logic signed [49:0] ACC_MAX  = 50'sd140737488355327;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

// File: design/bpd_if.sv
interface bpd_tick_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pitch_rad;
  logic [19:0]        elapsed_us;
  logic [31:0]        now_us;
  logic signed [15:0] forward_speed;
  logic signed [15:0] turn_rate;
  modport source(output valid, pitch_rad, elapsed_us, now_us, forward_speed, turn_rate,
                 input ready);
  modport sink(input valid, pitch_rad, elapsed_us, now_us, forward_speed, turn_rate,
               output ready);
endinterface

interface bpd_drive_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_wheel_speed;
  logic signed [15:0] right_wheel_speed;
  logic signed [15:0] pid_command;
  logic [15:0]        episode_count;
  logic [15:0]        step_count;
  logic               restarted;
  logic               fallen;
  modport source(output valid, left_wheel_speed, right_wheel_speed, pid_command,
                 episode_count, step_count, restarted, fallen, input ready);
  modport sink(input valid, left_wheel_speed, right_wheel_speed, pid_command,
               episode_count, step_count, restarted, fallen, output ready);
endinterface

// File: design/bpd_mul.sv
module bpd_mul #(
  parameter int A_W = bpd_pkg::MUL_A_W,
  parameter int B_W = bpd_pkg::MUL_B_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output logic           done,
  output logic [A_W-1:0] prod
);
  logic           busy;
  logic [A_W-1:0] ar;
  logic [B_W-1:0] br;

  // Shift-add, one multiplier bit a cycle; stop once no bits remain
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        ar   <= a;
        br   <= b;
        prod <= '0;
      end else if (busy) begin
        if (br == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (br[0]) prod <= prod + ar;
          ar <= {ar[A_W-2:0], 1'b0};
          br <= {1'b0, br[B_W-1:1]};
        end
      end
    end
  end
endmodule

// File: design/bpd_div.sv
module bpd_div #(
  parameter int N_W = bpd_pkg::DIV_N_W,
  parameter int D_W = bpd_pkg::DIV_D_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic           done,
  output logic [N_W-1:0] quo
);
  localparam int CNT_W = $clog2(N_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(N_W - 1);

  logic             busy;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dr;
  logic [CNT_W-1:0] cnt;
  logic [D_W:0]     trial;

  assign trial = {rem, quo[N_W-1]};

  // Restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quo  <= num;
        dr   <= den;
        rem  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dr}) begin
          rem <= D_W'(trial - {1'b0, dr});
          quo <= {quo[N_W-2:0], 1'b1};
        end else begin
          rem <= trial[D_W-1:0];
          quo <= {quo[N_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: design/balance_pid_drive_controller.sv
// Channel  Dir  Word contents
// -------  ---  ---------------------------------------------------------
// tick     in   pitch_rad, elapsed_us, now_us, forward_speed, turn_rate
// drive    out  wheel speeds, pid_command, episode/step counts, flags
// cfg_*    in   write enable, register index, 16-bit data
//
// One tick at a time. A balance tick runs six serial multiplies (one
// multiplier bit a cycle, stopping once no bits remain) and two passes of
// the shared divider. Tractor takes one multiply and two divisions; park
// none. Reset (rst, synchronous) loads the register defaults and clears
// the controller state, the sequencer and the output valid flag.
// A finished word waits in the output register; a new tick is taken while it
// waits, and the next result holds until the drive side takes the old one.
module balance_pid_drive_controller (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  bpd_tick_if.sink     tick,
  bpd_drive_if.source  drive
);
  import bpd_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ERR    = 4'd1;
  localparam logic [3:0] S_P      = 4'd2;
  localparam logic [3:0] S_INT    = 4'd3;
  localparam logic [3:0] S_IMUL   = 4'd4;
  localparam logic [3:0] S_IDIV   = 4'd5;
  localparam logic [3:0] S_DMUL   = 4'd6;
  localparam logic [3:0] S_DSCL   = 4'd7;
  localparam logic [3:0] S_DDIV   = 4'd8;
  localparam logic [3:0] S_SUM    = 4'd9;
  localparam logic [3:0] S_TROT   = 4'd10;
  localparam logic [3:0] S_TLEFT  = 4'd11;
  localparam logic [3:0] S_TRIGHT = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  // Configuration registers
  logic [1:0]  mode;
  logic [15:0] gain_p, gain_i, gain_d, sep, radius;
  logic [14:0] limit, fall_angle;

  // Controller state
  logic signed [47:0] acc;
  logic signed [23:0] prev;
  logic [15:0]        episodes, steps;
  logic [31:0]        last_fall;

  // Latched tick word and working values
  logic [3:0]         state;
  logic               kick;
  logic               kick_next;
  logic               pitch_neg;
  logic [19:0]        dt;
  logic [31:0]        now;
  logic signed [15:0] fwd, turn;
  logic signed [17:0] err;
  logic               err_neg;
  logic [16:0]        err_mag;
  logic signed [63:0] p_val, i_val;
  logic signed [24:0] diff;
  logic signed [33:0] num_l, num_r;
  logic signed [15:0] left, right, cmd;
  logic [15:0]        step_out;
  logic               restarted, fallen;

  // Shared units
  logic [63:0] mul_a, mul_prod, div_n, div_q;
  logic [31:0] mul_b, div_d;
  logic        mul_done, div_done;
  logic        mul_start, div_start;

  // Datapath helpers
  logic [15:0]        pitch_in_abs, turn_in_abs;
  logic [63:0]        err_round, p_round;
  logic [16:0]        err_mag_c;
  logic               err_neg_c;
  logic signed [17:0] err_c;
  logic               fall_c, restart_c;
  logic signed [49:0] inc, acc_sum;
  logic signed [47:0] acc_sat;
  logic [47:0]        acc_abs;
  logic signed [24:0] diff_c;
  logic [24:0]        diff_abs;
  logic signed [63:0] d_val, total;
  logic signed [63:0] lim;
  logic signed [33:0] lin, rot, nl, nr;
  logic [33:0]        nl_abs, nr_abs;
  logic [15:0]        r_eff;
  logic signed [63:0] q_s;
  logic               out_load;

  assign mul_start = kick && (state == S_ERR || state == S_P || state == S_INT ||
                              state == S_IMUL || state == S_DMUL || state == S_DSCL ||
                              state == S_TROT);
  assign div_start = kick && (state == S_IDIV || state == S_DDIV ||
                              state == S_TLEFT || state == S_TRIGHT);

  bpd_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  bpd_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_n), .den(div_d),
    .done(div_done), .quo(div_q)
  );

  // Start the next serial operation right after the previous one finishes
  always_comb begin
    case (state)
      S_IDLE:                            kick_next = tick.valid;
      S_ERR, S_P, S_INT, S_IMUL,
      S_DMUL, S_DSCL, S_TROT:            kick_next = mul_done;
      S_IDIV, S_TLEFT:                   kick_next = div_done;
      default:                           kick_next = 1'b0;
    endcase
  end

  always_comb begin
    // Magnitudes of the incoming signed fields, -32768 giving 32768
    pitch_in_abs = tick.pitch_rad[15] ? 16'(-tick.pitch_rad) : 16'(tick.pitch_rad);
    turn_in_abs  = tick.turn_rate[15] ? 16'(-tick.turn_rate) : 16'(tick.turn_rate);
    // Degrees from radians, rounded on the magnitude
    err_round = mul_prod + 64'h0000_0000_0010_0000;
    err_mag_c = err_round[37:21];
    err_neg_c = pitch_neg && (err_mag_c != '0);
    err_c     = err_neg_c ? -$signed({1'b0, err_mag_c}) : $signed({1'b0, err_mag_c});
    fall_c    = err_mag_c > {2'b0, fall_angle};
    restart_c = fall_c && (32'(now - last_fall) > FALL_DEBOUNCE);
    p_round   = mul_prod + 64'd128;
    // Integral step, saturated
    inc       = err_neg ? -$signed({14'd0, mul_prod[35:0]})
                        :  $signed({14'd0, mul_prod[35:0]});
    acc_sum   = {{2{acc[47]}}, acc} + inc;
    acc_sat   = (acc_sum > ACC_MAX) ? ACC_MAX[47:0] :
                (acc_sum < -ACC_MAX) ? 48'(-ACC_MAX) : acc_sum[47:0];
    acc_abs   = acc_sat[47] ? 48'(-acc_sat) : 48'(acc_sat);
    diff_c    = {{7{err[17]}}, err} - {prev[23], prev};
    diff_abs  = diff_c[24] ? 25'(-diff_c) : 25'(diff_c);
    d_val     = diff[24] ? -$signed(div_q) : $signed(div_q);
    total     = p_val + i_val + d_val;
    lim       = $signed({49'd0, limit});
    // Differential drive
    lin       = {{5{fwd[15]}}, fwd, 13'd0};
    rot       = turn[15] ? -$signed({3'd0, mul_prod[30:0]}) : $signed({3'd0, mul_prod[30:0]});
    nl        = lin - rot;
    nr        = lin + rot;
    nl_abs    = nl[33] ? 34'(-nl) : 34'(nl);
    nr_abs    = nr[33] ? 34'(-nr) : 34'(nr);
    r_eff     = (radius == '0) ? 16'd1 : radius;
    q_s       = $signed(div_q);
    out_load  = (state == S_OUT) && (!drive.valid || drive.ready);
  end

  assign tick.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_BALANCE;
      gain_p     <= RST_GAIN_P;
      gain_i     <= RST_GAIN_I;
      gain_d     <= RST_GAIN_D;
      sep        <= RST_SEP;
      radius     <= RST_RADIUS;
      limit      <= RST_LIMIT;
      fall_angle <= RST_FALL;
      acc        <= '0;
      prev       <= '0;
      episodes   <= '0;
      steps      <= '0;
      last_fall  <= '0;
      state      <= S_IDLE;
      kick       <= 1'b0;
      drive.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:   mode       <= cfg_data[1:0];
          REG_GAIN_P: gain_p     <= cfg_data;
          REG_GAIN_I: gain_i     <= cfg_data;
          REG_GAIN_D: gain_d     <= cfg_data;
          REG_SEP:    sep        <= cfg_data;
          REG_RADIUS: radius     <= cfg_data;
          REG_LIMIT:  limit      <= cfg_data[14:0];
          REG_FALL:   fall_angle <= cfg_data[14:0];
          default: ;
        endcase
      end

      // Load a new word, or drop the old one once taken
      if (out_load) drive.valid <= 1'b1;
      else if (drive.ready) drive.valid <= 1'b0;
      kick <= kick_next;

      case (state)
        S_IDLE: begin
          if (tick.valid) begin
            // Latch the word; outputs default to the park result
            pitch_neg <= tick.pitch_rad[15];
            dt        <= (tick.elapsed_us == '0) ? 20'd1 : tick.elapsed_us;
            now       <= tick.now_us;
            fwd       <= tick.forward_speed;
            turn      <= tick.turn_rate;
            left      <= '0;
            right     <= '0;
            cmd       <= '0;
            restarted <= 1'b0;
            fallen    <= 1'b0;
            step_out  <= steps;
            if (mode == MODE_BALANCE) begin
              state <= S_ERR;
              mul_a <= 64'(DEG_PER_RAD_Q16);
              mul_b <= 32'(pitch_in_abs);
            end else if (mode == MODE_TRACTOR) begin
              state <= S_TROT;
              mul_a <= 64'(turn_in_abs);
              mul_b <= 32'(sep);
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_ERR: begin
          if (mul_done) begin
            err      <= err_c;
            err_neg  <= err_neg_c;
            err_mag  <= err_mag_c;
            step_out <= restart_c ? 16'd0 : steps;
            // Fall check; clear the controller on a debounced fall
            if (fall_c) begin
              fallen    <= 1'b1;
              last_fall <= now;
              if (restart_c) begin
                restarted <= 1'b1;
                acc       <= '0;
                prev      <= '0;
                episodes  <= episodes + 1'b1;
                steps     <= '0;
              end
            end
            mul_a <= 64'(err_mag_c);
            mul_b <= 32'(gain_p);
            state <= S_P;
          end
        end
        S_P: begin
          if (mul_done) begin
            p_val <= err_neg ? -$signed({8'd0, p_round[63:8]}) : $signed({8'd0, p_round[63:8]});
            mul_a <= 64'(err_mag);
            mul_b <= 32'(dt);
            state <= S_INT;
          end
        end
        S_INT: begin
          if (mul_done) begin
            acc   <= acc_sat;
            mul_a <= 64'(acc_abs);
            mul_b <= 32'(gain_i);
            state <= S_IMUL;
          end
        end
        S_IMUL: begin
          if (mul_done) begin
            div_n <= mul_prod + 64'(I_SCALE_HALF);
            div_d <= I_SCALE;
            state <= S_IDIV;
          end
        end
        S_IDIV: begin
          if (div_done) begin
            i_val <= acc[47] ? -q_s : q_s;
            diff  <= diff_c;
            mul_a <= 64'(diff_abs);
            mul_b <= 32'(gain_d);
            state <= S_DMUL;
          end
        end
        S_DMUL: begin
          if (mul_done) begin
            mul_a <= mul_prod;
            mul_b <= US_PER_S;
            state <= S_DSCL;
          end
        end
        S_DSCL: begin
          if (mul_done) begin
            div_n <= mul_prod + {37'd0, dt, 7'd0};
            div_d <= {4'd0, dt, 8'd0};
            state <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (div_done) begin
            prev  <= 24'(err);
            state <= S_SUM;
          end
        end
        S_SUM: begin
          // Clamp and drive the wheels in opposite senses
          if (total > lim) begin
            cmd <= 16'(lim); right <= 16'(lim); left <= 16'(-lim);
          end else if (total < -lim) begin
            cmd <= 16'(-lim); right <= 16'(-lim); left <= 16'(lim);
          end else begin
            cmd <= total[15:0]; right <= total[15:0]; left <= 16'(-total);
          end
          steps <= steps + 1'b1;
          state <= S_OUT;
        end
        S_TROT: begin
          if (mul_done) begin
            num_l <= nl;
            num_r <= nr;
            div_n <= 64'(nl_abs) + 64'(r_eff);
            div_d <= 32'({r_eff, 1'b0});
            state <= S_TLEFT;
          end
        end
        S_TLEFT: begin
          if (div_done) begin
            left  <= sat16(num_l[33] ? q_s : -q_s);
            div_n <= 64'(nr_abs) + 64'(r_eff);
            state <= S_TRIGHT;
          end
        end
        S_TRIGHT: begin
          if (div_done) begin
            right <= sat16(num_r[33] ? -q_s : q_s);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold until the output register is free
          if (out_load) begin
            drive.left_wheel_speed  <= left;
            drive.right_wheel_speed <= right;
            drive.pid_command       <= cmd;
            drive.episode_count     <= episodes;
            drive.step_count        <= step_out;
            drive.restarted         <= restarted;
            drive.fallen            <= fallen;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A restart only ever follows a detected fall
  a_restart_fallen: assert property (@(posedge clk) disable iff (rst)
    drive.valid && drive.restarted |-> drive.fallen)
    else $error("restart without fall");

  // A nonzero command drives the wheels as -cmd and +cmd
  a_balance_wheels: assert property (@(posedge clk) disable iff (rst)
    drive.valid && drive.pid_command != 16'sd0 |->
      drive.right_wheel_speed == drive.pid_command &&
      drive.left_wheel_speed == -drive.pid_command)
    else $error("wheel speeds disagree with command");

  // An accepted tick always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready |=> state != S_IDLE)
    else $error("tick accepted but sequencer idle");

  // The shared units never finish in the same cycle
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_done && div_done))
    else $error("multiplier and divider overlap");
endmodule

// File: tb/bpd_tb_if.sv
`timescale 1ns / 100ps
// Channel interfaces are supplied with the design (bpd_tick_if, bpd_drive_if).
// This file only holds the pacing helper shared by the bench.
package bpd_tb_pkg;
  typedef enum logic [1:0] {PACE_SRC_SLOW, PACE_SINK_SLOW, PACE_NONE} pace_t;
endpackage

// File: tb/tb_balance_pid_drive_controller.sv
`timescale 1ns / 100ps
module tb_balance_pid_drive_controller;
  import bpd_pkg::*;
  import bpd_tb_pkg::*;

  localparam longint ACC_LIM = 64'sd140737488355327;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk, rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  bpd_tick_if tick();
  bpd_drive_if drive();

  balance_pid_drive_controller dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .tick(tick), .drive(drive)
  );

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [15:0] cmd;
    logic [15:0] episodes;
    logic [15:0] steps;
    logic restarted;
    logic fallen;
  } drive_word_t;

  typedef struct {
    logic signed [15:0] pitch;
    logic [19:0] dt;
    logic [31:0] now;
    logic signed [15:0] fwd;
    logic signed [15:0] turn;
    bit has_golden;
    drive_word_t golden;
  } tick_row_t;

  // shadow of the block's registers and controller state
  logic [1:0] m_mode;
  logic [15:0] m_kp, m_ki, m_kd, m_sep, m_rad;
  logic [14:0] m_limit, m_fall;
  longint m_integ, m_prev_err;
  logic [15:0] m_episodes, m_steps;
  logic [31:0] m_last_fall;

  drive_word_t pending_words[$];
  int errors = 0;
  int cycles = 0;
  pace_t pace = PACE_NONE;
  bit hold_sink = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Cycle watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint rdiv(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void model_reset();
    m_mode = MODE_BALANCE; m_kp = RST_GAIN_P; m_ki = RST_GAIN_I; m_kd = RST_GAIN_D;
    m_sep = RST_SEP; m_rad = RST_RADIUS; m_limit = RST_LIMIT; m_fall = RST_FALL;
    m_integ = 0; m_prev_err = 0; m_episodes = 0; m_steps = 0; m_last_fall = 0;
  endfunction

  // Advance the controller shadow by one tick and return the drive word.
  function automatic drive_word_t predict_drive(tick_row_t t);
    drive_word_t w;
    longint dt, err, mag, p, i, d, cmd, r2, lin, rot, lft, rgt;
    logic [31:0] since;
    dt = (t.dt == 0) ? 1 : longint'(t.dt);
    cmd = 0; lft = 0; rgt = 0;
    w = '0;
    if (m_mode == MODE_BALANCE) begin
      err = rdiv(longint'(t.pitch) * 3754936, 64'sd1 << 21);
      mag = err < 0 ? -err : err;
      if (mag > longint'(m_fall)) begin
        w.fallen = 1;
        since = t.now - m_last_fall;
        if (since > FALL_DEBOUNCE) begin
          w.restarted = 1;
          m_integ = 0; m_prev_err = 0;
          m_episodes = m_episodes + 16'd1;
          m_steps = 0;
        end
        m_last_fall = t.now;
      end
      w.steps = m_steps;
      p = rdiv(err * longint'(m_kp), 256);
      m_integ = clip(m_integ + err * dt, -ACC_LIM, ACC_LIM);
      // product stays inside 64 bits: below 2^47 * 2^16, so it fits
      i = rdiv(m_integ * longint'(m_ki), 64'sd256000000);
      d = rdiv((err - m_prev_err) * longint'(m_kd) * 1000000, dt * 256);
      m_prev_err = err;
      cmd = clip(p + i + d, -longint'(m_limit), longint'(m_limit));
      lft = -cmd; rgt = cmd;
      m_steps = m_steps + 16'd1;
    end else begin
      w.steps = m_steps;
      if (m_mode == MODE_TRACTOR) begin
        r2 = 2 * ((m_rad == 0) ? 1 : longint'(m_rad));
        lin = 2 * longint'(t.fwd) * 4096;
        rot = longint'(t.turn) * longint'(m_sep);
        lft = clip(-rdiv(lin - rot, r2), -32768, 32767);
        rgt = clip(rdiv(lin + rot, r2), -32768, 32767);
      end
    end
    w.left = lft[15:0]; w.right = rgt[15:0]; w.cmd = cmd[15:0];
    w.episodes = m_episodes;
    return w;
  endfunction

  // Sink: random stalls per pace, check each word at the accepting edge.
  always @(negedge clk) begin
    if (rst) drive.ready <= 0;
    else if (hold_sink) drive.ready <= 1;
    else case (pace)
      PACE_SRC_SLOW:  drive.ready <= ($urandom_range(99) >= 67);
      PACE_SINK_SLOW: drive.ready <= ($urandom_range(99) >= 38);
      default:        drive.ready <= 1;
    endcase
  end

  always @(posedge clk) begin
    drive_word_t got, want;
    if (!rst && drive.valid && drive.ready) begin
      got = '{drive.left_wheel_speed, drive.right_wheel_speed, drive.pid_command,
              drive.episode_count, drive.step_count, drive.restarted, drive.fallen};
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected drive word %h", $time, got);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          $display("%0t: drive mismatch expected l=%0d r=%0d c=%0d e=%0d s=%0d rs=%0b f=%0b",
                   $time, want.left, want.right, want.cmd, want.episodes, want.steps,
                   want.restarted, want.fallen);
          $display("%0t:                actual   l=%0d r=%0d c=%0d e=%0d s=%0d rs=%0b f=%0b",
                   $time, got.left, got.right, got.cmd, got.episodes, got.steps,
                   got.restarted, got.fallen);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      REG_MODE:   m_mode = val[1:0];
      REG_GAIN_P: m_kp = val;
      REG_GAIN_I: m_ki = val;
      REG_GAIN_D: m_kd = val;
      REG_SEP:    m_sep = val;
      REG_RADIUS: m_rad = val;
      REG_LIMIT:  m_limit = val[14:0];
      REG_FALL:   m_fall = val[14:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Drain: wait until every word is back, then let the block settle.
  task automatic drain();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Send one tick word; check or predict its result.
  task automatic send_tick(tick_row_t t);
    drive_word_t w;
    int idle_pct;
    idle_pct = (pace == PACE_SRC_SLOW) ? 38 : (pace == PACE_SINK_SLOW) ? 67 : 0;
    while ($urandom_range(99) < idle_pct) begin
      tick.valid = 0;
      @(negedge clk);
    end
    tick.valid = 1;
    tick.pitch_rad = t.pitch; tick.elapsed_us = t.dt; tick.now_us = t.now;
    tick.forward_speed = t.fwd; tick.turn_rate = t.turn;
    w = predict_drive(t);
    if (t.has_golden && w !== t.golden) begin
      $display("%0t: predictor disagrees with table expected %h actual %h",
               $time, t.golden, w);
      errors++;
    end
    pending_words.push_back(t.has_golden ? t.golden : w);
    do @(posedge clk); while (!tick.ready);
    @(negedge clk);
    tick.valid = 0;
  endtask

  function automatic tick_row_t row(int p, int dt, logic [31:0] now, int f, int tr);
    tick_row_t r;
    r.pitch = 16'(p); r.dt = 20'(dt); r.now = now; r.fwd = 16'(f); r.turn = 16'(tr);
    r.has_golden = 0; r.golden = '0;
    return r;
  endfunction

  function automatic tick_row_t gold(tick_row_t r, drive_word_t g);
    r.has_golden = 1; r.golden = g;
    return r;
  endfunction

  // Random balance pitch: mostly near upright, sometimes a tilt past the limit.
  function automatic tick_row_t rand_row(ref logic [31:0] clock_us);
    tick_row_t r;
    int k;
    k = $urandom_range(99);
    clock_us = clock_us + $urandom_range(1, 60000);
    if (k < 10) clock_us = clock_us + $urandom_range(100000, 300000);
    r = row(0, $urandom_range(1, 80000), clock_us, $urandom, $urandom);
    if (k < 60) r.pitch = $signed(16'($urandom_range(0, 6000))) - 16'sd3000;
    else r.pitch = 16'($urandom);
    if ($urandom_range(99) < 5) r.dt = 20'($urandom);
    if ($urandom_range(99) < 3) r.now = $urandom;
    return r;
  endfunction

  tick_row_t dir_rows[$];
  logic [31:0] clock_us;
  int phase;

  initial begin
    rst = 1; cfg_we = 0; cfg_index = REG_MODE; cfg_data = 0;
    tick.valid = 0; tick.pitch_rad = 0; tick.elapsed_us = 0; tick.now_us = 0;
    tick.forward_speed = 0; tick.turn_rate = 0;
    model_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed table, balance mode at reset defaults.
    // Upright tick right after reset: everything zero.
    dir_rows.push_back(gold(row(0, 50000, 1000, 0, 0), '{0, 0, 0, 0, 0, 0, 0}));
    // Full tilt right within debounce of time zero: fallen, no restart.
    dir_rows.push_back(gold(row(32767, 50000, 50000, 0, 0),
                            '{-16'sd15360, 16'sd15360, 16'sd15360, 0, 1, 0, 1}));
    // Full negative tilt long after: restart, step count back to zero.
    dir_rows.push_back(row(-32768, 50000, 400000, 0, 0));
    // Zero elapsed time counts as one microsecond.
    dir_rows.push_back(row(100, 0, 450000, 0, 0));
    dir_rows.push_back(row(-100, 1048575, 500000, 32767, -32768));
    // Time wraps across the 32-bit boundary.
    dir_rows.push_back(row(32767, 10, 32'hFFFF_FFF0, 0, 0));
    dir_rows.push_back(row(32767, 10, 32'h0002_0000, 0, 0));
    foreach (dir_rows[n]) send_tick(dir_rows[n]);
    drain();

    // Park and undefined mode drive zero and leave the controller alone.
    write_reg(REG_MODE, MODE_PARK);
    send_tick(gold(row(32767, 1, 5, 32767, 32767), '{0, 0, 0, 3, 1, 0, 0}));
    drain();
    write_reg(REG_MODE, 16'd3);
    send_tick(row(-32768, 20, 7, -32768, -32768));
    drain();

    // Tractor: extremes of radius and separation, including zero radius.
    write_reg(REG_MODE, MODE_TRACTOR);
    write_reg(REG_RADIUS, 16'd0);
    write_reg(REG_SEP, 16'hFFFF);
    send_tick(gold(row(0, 1, 0, 32767, 32767), '{16'sd32767, 16'sd32767, 0, 3, 1, 0, 0}));
    send_tick(row(0, 1, 0, -32768, 1));
    drain();
    write_reg(REG_RADIUS, 16'hFFFF);
    send_tick(row(0, 1, 0, 256, -256));
    send_tick(row(0, 1, 0, -32768, -32768));
    drain();

    // Random phases over several register settings.
    clock_us = 32'd1_000_000;
    for (phase = 0; phase < 8; phase++) begin
      pace = (phase < 3) ? PACE_SRC_SLOW : (phase < 6) ? PACE_SINK_SLOW : PACE_NONE;
      case (phase)
        0: begin
          write_reg(REG_MODE, MODE_BALANCE);
        end
        1: begin
          write_reg(REG_GAIN_P, 16'hFFFF); write_reg(REG_GAIN_I, 16'hFFFF);
          write_reg(REG_GAIN_D, 16'hFFFF); write_reg(REG_LIMIT, 15'h7FFF);
          write_reg(REG_FALL, 15'd0);
        end
        2: begin
          write_reg(REG_GAIN_P, 16'd0); write_reg(REG_GAIN_I, 16'd0);
          write_reg(REG_GAIN_D, 16'd0); write_reg(REG_LIMIT, 15'd0);
          write_reg(REG_FALL, 15'h7FFF);
        end
        7: begin
          write_reg(REG_MODE, MODE_TRACTOR);
          write_reg(REG_SEP, 16'd1); write_reg(REG_RADIUS, 16'd1);
        end
        default: begin
          write_reg(REG_GAIN_P, 16'($urandom));
          write_reg(REG_GAIN_I, 16'($urandom_range(0, 400)));
          write_reg(REG_GAIN_D, 16'($urandom_range(0, 400)));
          write_reg(REG_LIMIT, 16'($urandom_range(1000, 32767)));
          write_reg(REG_FALL, 16'($urandom_range(2000, 12000)));
          write_reg(REG_SEP, 16'($urandom_range(1, 65535)));
          write_reg(REG_RADIUS, 16'($urandom_range(1, 65535)));
          write_reg(REG_MODE, (phase == 5) ? MODE_TRACTOR : MODE_BALANCE);
        end
      endcase
      repeat (100) begin
        send_tick(rand_row(clock_us));
        // in phase 4, hold off whenever one word is outstanding so the pipeline empties mid-run
        if (phase == 4 && pending_words.size() == 1) begin
          while (pending_words.size() != 0) @(posedge clk);
          @(negedge clk);
        end
      end
      drain();
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

// File: filelist.f
design/bpd_pkg.sv
design/bpd_if.sv
design/bpd_mul.sv
design/bpd_div.sv
design/balance_pid_drive_controller.sv
tb/bpd_tb_if.sv
tb/tb_balance_pid_drive_controller.sv
